>>> hdl/varint_zigzag_codec_top_assert.svh
// Assertion macros used by the varint codec datapath.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef VARINT_ZIGZAG_CODEC_TOP_ASSERT_SVH
`define VARINT_ZIGZAG_CODEC_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define VZC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define VZC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define VZC_ASSERT_NOW(label, ante, cons)
`define VZC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hdl/vzc_pkg.sv
// Shared types and constants for the varint / zigzag codec.
// No dependencies.
package vzc_pkg;

  localparam int unsigned VAL_W      = 64;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned IN_DATA_W  = 80;  // 64 + 8 + 1 + 1, padded to bytes
  localparam int unsigned OUT_DATA_W = 80;  // 8 + 64 + 1, padded to bytes

  localparam logic [CNT_W-1:0] MAX_BYTES_NARROW = 4'd5;
  localparam logic [CNT_W-1:0] MAX_BYTES_WIDE   = 4'd10;
  localparam logic [CNT_W-1:0] ENC_LAST_IDX     = 4'd9;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_VALUE = 1'b1
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic load_enc;   // latch a value to encode
    logic emit_enc;   // emit next encoded byte to output register
    logic step_dec;   // absorb one decode byte
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic enc_last;   // byte now pending is the final one
    logic dec_done;   // incoming decode byte finishes a value
  } dp_status_t;

endpackage

>>> hdl/vzc_ctrl.sv
// Controller FSM for the varint codec: handshakes and sequencing.
// Depends on vzc_pkg.
module vzc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_cmd,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  vzc_pkg::dp_status_t status,
  output vzc_pkg::ctrl_cmd_t  cmd
);
  import vzc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_ENC  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   accept;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && slot_free;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_t'(in_cmd) == CMD_ENCODE) begin
            cmd.load_enc = 1'b1;
            state_nxt    = ST_ENC;
          end else begin
            cmd.step_dec = 1'b1;
            if (status.dec_done) out_valid_nxt = 1'b1;
          end
        end
      end
      ST_ENC: begin
        if (slot_free) begin
          cmd.emit_enc  = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.enc_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/vzc_datapath.sv
// Datapath for the varint codec: encode shifter, decode accumulator,
// zigzag mapping and output register. Depends on vzc_pkg and the assert header.
`include "varint_zigzag_codec_top_assert.svh"

module vzc_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vzc_pkg::ctrl_cmd_t          cmd,
  output vzc_pkg::dp_status_t         status,
  input  logic [vzc_pkg::VAL_W-1:0]   value_in,
  input  logic [vzc_pkg::BYTE_W-1:0]  byte_in,
  input  logic                        wide,
  input  logic                        signed_mode,
  output logic                        kind,
  output logic [vzc_pkg::BYTE_W-1:0]  byte_out,
  output logic [vzc_pkg::VAL_W-1:0]   value_out,
  output logic                        last,
  output logic                        overlong
);
  import vzc_pkg::*;

  // encode side
  logic [VAL_W-1:0] enc_val_r, enc_val_nxt;
  logic [CNT_W-1:0] enc_cnt_r, enc_cnt_nxt;
  logic [VAL_W-1:0] enc_mapped;
  logic [31:0]      enc_x;
  logic [BYTE_W-1:0] enc_byte;

  // decode side
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] dec_cnt_r, dec_cnt_nxt;
  logic             in_prog_r, in_prog_nxt;
  logic             lat_wide_r, lat_wide_nxt;
  logic             lat_sgn_r, lat_sgn_nxt;

  logic             eff_wide, eff_sgn, cont;
  logic [VAL_W-1:0] acc_base, acc_sum;
  logic [CNT_W-1:0] cnt_base, cnt_inc;
  logic [5:0]       shamt;
  logic [31:0]      nx, nz;
  logic [VAL_W-1:0] dec_value;

  // output register
  logic              kind_r, last_r, ovl_r;
  logic [BYTE_W-1:0] byte_r;
  logic [VAL_W-1:0]  value_r;

  // ---------------- encode ----------------
  assign enc_x = value_in[31:0];
  always_comb begin
    if (wide)
      enc_mapped = signed_mode ? ((value_in << 1) ^ {VAL_W{value_in[VAL_W-1]}}) : value_in;
    else
      enc_mapped = signed_mode ? {32'd0, (enc_x << 1) ^ {32{enc_x[31]}}} : {32'd0, enc_x};
  end

  assign status.enc_last = (enc_val_r[VAL_W-1:7] == '0) || (enc_cnt_r == ENC_LAST_IDX);
  assign enc_byte = status.enc_last ? enc_val_r[7:0] : {1'b1, enc_val_r[6:0]};

  always_comb begin
    enc_val_nxt = enc_val_r;
    enc_cnt_nxt = enc_cnt_r;
    if (cmd.load_enc) begin
      enc_val_nxt = enc_mapped;
      enc_cnt_nxt = '0;
    end else if (cmd.emit_enc) begin
      enc_val_nxt = enc_val_r >> 7;
      enc_cnt_nxt = status.enc_last ? '0 : enc_cnt_r + 4'd1;
    end
  end

  // ---------------- decode ----------------
  // first byte of a value latches width/mode and starts from an empty accumulator
  assign eff_wide = in_prog_r ? lat_wide_r : wide;
  assign eff_sgn  = in_prog_r ? lat_sgn_r  : signed_mode;
  assign acc_base = in_prog_r ? acc_r      : '0;
  assign cnt_base = in_prog_r ? dec_cnt_r  : '0;
  assign cont     = byte_in[7];

  assign shamt   = 6'({3'd0, cnt_base} * 7'd7);   // count never passes 9
  assign acc_sum = eff_wide ? (acc_base | ({57'd0, byte_in[6:0]} << shamt))
                            : {32'd0, acc_base[31:0] | 32'({57'd0, byte_in[6:0]} << shamt)};
  assign cnt_inc = cnt_base + 4'd1;

  assign status.dec_done = !cont ||
                           (cnt_inc >= (eff_wide ? MAX_BYTES_WIDE : MAX_BYTES_NARROW));

  // zigzag unmap
  assign nx = acc_sum[31:0];
  assign nz = (nx >> 1) ^ {32{nx[0]}};
  always_comb begin
    if (eff_wide)
      dec_value = eff_sgn ? ((acc_sum >> 1) ^ {VAL_W{acc_sum[0]}}) : acc_sum;
    else
      dec_value = eff_sgn ? {{32{nz[31]}}, nz} : {32'd0, nx};
  end

  always_comb begin
    acc_nxt      = acc_r;
    dec_cnt_nxt  = dec_cnt_r;
    in_prog_nxt  = in_prog_r;
    lat_wide_nxt = lat_wide_r;
    lat_sgn_nxt  = lat_sgn_r;
    if (cmd.step_dec) begin
      lat_wide_nxt = eff_wide;
      lat_sgn_nxt  = eff_sgn;
      if (status.dec_done) begin
        acc_nxt     = '0;
        dec_cnt_nxt = '0;
        in_prog_nxt = 1'b0;
      end else begin
        acc_nxt     = acc_sum;
        dec_cnt_nxt = cnt_inc;
        in_prog_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_cnt_r  <= '0;
      acc_r      <= '0;
      dec_cnt_r  <= '0;
      in_prog_r  <= 1'b0;
      lat_wide_r <= 1'b0;
      lat_sgn_r  <= 1'b0;
    end else begin
      enc_cnt_r  <= enc_cnt_nxt;
      acc_r      <= acc_nxt;
      dec_cnt_r  <= dec_cnt_nxt;
      in_prog_r  <= in_prog_nxt;
      lat_wide_r <= lat_wide_nxt;
      lat_sgn_r  <= lat_sgn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    enc_val_r <= enc_val_nxt;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (cmd.emit_enc) begin
      kind_r  <= KIND_BYTE;
      byte_r  <= enc_byte;
      value_r <= '0;
      last_r  <= status.enc_last;
      ovl_r   <= 1'b0;
    end else if (cmd.step_dec && status.dec_done) begin
      kind_r  <= KIND_VALUE;
      byte_r  <= '0;
      value_r <= dec_value;
      last_r  <= 1'b1;
      ovl_r   <= cont;
    end
  end

  assign kind      = kind_r;
  assign byte_out  = byte_r;
  assign value_out = value_r;
  assign last      = last_r;
  assign overlong  = ovl_r;

  // ---------------- checks ----------------
  `VZC_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0(cmd))
  `VZC_ASSERT_NOW(a_enc_cnt_range, 1'b1, enc_cnt_r <= ENC_LAST_IDX)
  `VZC_ASSERT_NOW(a_dec_cnt_range, 1'b1, dec_cnt_r < (lat_wide_r ? MAX_BYTES_WIDE : MAX_BYTES_NARROW))
  `VZC_ASSERT_NEXT(a_dec_clears, cmd.step_dec && status.dec_done, !in_prog_r && dec_cnt_r == '0)

endmodule

>>> hdl/varint_zigzag_codec_top.sv
// Top level of the base-128 varint codec with zigzag signed mapping.
// Depends on vzc_pkg, vzc_ctrl and vzc_datapath.
//
// Usage:
//   Input channel (in_*): one word per item. in_tuser is the command:
//   encode a value or decode one byte. Output channel (out_*): one word per
//   encoded byte, or one word per finished decoded value.
//   Encode: a value is loaded, then emits 1 to 5 (32-bit) or
//   1 to 10 (64-bit) bytes at one per cycle while the output is not held;
//   the input stays closed until the final byte (out_tlast high) has gone
//   into the output register. Decode: one byte per cycle while the input
//   is open. Bytes that do not end a value give no word; the ending byte
//   loads the value into the output register, visible the next cycle.
//   Width and signed mode are latched at a value's first byte. The encode
//   rate is set by the single encode shifter, one byte per cycle unless stalled.
//   Stall: a held output register closes the input (decode) or pauses the
//   encode shifter; nothing is dropped.
//   Reset (rst_n low, synchronous): output empty, decode state cleared,
//   encode sequence abandoned.
module varint_zigzag_codec_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [63:0] value_in, [71:64] byte_in, [72] wide, [73] signed_mode, [79:74] zero
  input  logic [vzc_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] command
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] byte_out, [71:8] value_out, [72] overlong, [79:73] zero
  output logic [vzc_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] kind
  output logic        out_tuser,
  output logic        out_tlast
);
  import vzc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic [VAL_W-1:0]  value_out;
  logic [BYTE_W-1:0] byte_out;
  logic              overlong;

  vzc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  vzc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .value_in    (in_tdata[63:0]),
    .byte_in     (in_tdata[71:64]),
    .wide        (in_tdata[72]),
    .signed_mode (in_tdata[73]),
    .kind        (out_tuser),
    .byte_out    (byte_out),
    .value_out   (value_out),
    .last        (out_tlast),
    .overlong    (overlong)
  );

  // pack result word, zero padding on top
  assign out_tdata = {7'd0, overlong, value_out, byte_out};

endmodule
